// ----- design/chte_pkg.sv -----
// Shared constants, codes and width helpers for the chained hash table engine.
`default_nettype none
package chte_pkg;

  localparam int MAX_BINS_DEF    = 256;
  localparam int BIN_SLOTS_DEF   = 8;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CFG_W    = 9;
  localparam int HASH_W   = 32;
  localparam int IOVAL_W  = 32;
  localparam int COUNT_W  = 12;
  localparam int STATUS_W = 3;
  localparam int ACTION_W = 2;

  localparam logic [CFG_W-1:0] BIN_COUNT_RST = 9'd20;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT      = 2'd0,
    ACT_GET      = 2'd1,
    ACT_REMOVE   = 2'd2,
    ACT_CONTAINS = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  // bins reachable through the 9-bit bin count
  function automatic int bin_depth(input int max_bins);
    return (max_bins < 511) ? max_bins : 511;
  endfunction

  function automatic int idx_w(input int n);
    return (n <= 2) ? 1 : $clog2(n);
  endfunction

endpackage
`default_nettype wire

// ----- design/chte_front.sv -----
// Front end: accepts request words and reduces the hash to a bin index.
`default_nettype none
module chte_front #(
  parameter int MAX_BINS    = chte_pkg::MAX_BINS_DEF,
  parameter int VALUE_WIDTH = chte_pkg::VALUE_WIDTH_DEF,
  localparam int BIN_W      = chte_pkg::idx_w(chte_pkg::bin_depth(MAX_BINS))
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [chte_pkg::CFG_W-1:0]        bin_count,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [chte_pkg::ACTION_W-1:0]     in_action,
  input  wire logic [chte_pkg::HASH_W-1:0]       in_key_hash,
  input  wire logic [chte_pkg::IOVAL_W-1:0]      in_value_in,
  output logic                                   q_push,
  input  wire logic                              q_full,
  output chte_pkg::action_t                      q_action,
  output logic [chte_pkg::HASH_W-1:0]            q_hash,
  output logic [VALUE_WIDTH-1:0]                 q_value,
  output logic [BIN_W-1:0]                       q_bin
);

  localparam int STEPS  = 8;  // four hash bits per cycle
  localparam int CNT_W  = 3;
  localparam int CW     = chte_pkg::CFG_W;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                          st_r, st_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  chte_pkg::action_t                act_r;
  logic [chte_pkg::HASH_W-1:0]      hash_r, sh_r, sh_nxt;
  logic [VALUE_WIDTH-1:0]           val_r;
  logic [CW-1:0]                    rem_r, rem_nxt;
  logic [CW-1:0]                    n_eff;
  logic [CW:0]                      t;
  logic [63:0]                      v64;

  always_comb begin
    if (bin_count == '0) begin
      n_eff = CW'(1);
    end else if (32'(bin_count) > 32'(MAX_BINS)) begin
      n_eff = CW'(MAX_BINS);
    end else begin
      n_eff = bin_count;
    end
  end

  // restoring remainder, four bits a cycle, msb first
  always_comb begin
    t = {1'b0, rem_r};
    for (int i = 0; i < 4; i++) begin
      t = {t[CW-1:0], sh_r[chte_pkg::HASH_W-1-i]};
      if (t >= {1'b0, n_eff}) begin
        t = t - {1'b0, n_eff};
      end
    end
    rem_nxt = t[CW-1:0];
    sh_nxt  = {sh_r[chte_pkg::HASH_W-5:0], 4'b0};
  end

  assign v64 = 64'(in_value_in);

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    case (st_r)
      F_IDLE: begin
        if (in_valid) begin
          st_nxt  = F_DIV;
          cnt_nxt = '0;
        end
      end
      F_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          st_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && in_valid) begin
      act_r  <= chte_pkg::action_t'(in_action);
      hash_r <= in_key_hash;
      sh_r   <= in_key_hash;
      val_r  <= v64[VALUE_WIDTH-1:0];
      rem_r  <= '0;
    end else if (st_r == F_DIV) begin
      sh_r  <= sh_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign in_stall = (st_r != F_IDLE);
  assign q_push   = (st_r == F_PUSH);
  assign q_action = act_r;
  assign q_hash   = hash_r;
  assign q_value  = val_r;
  assign q_bin    = rem_r[BIN_W-1:0];

endmodule
`default_nettype wire

// ----- design/chte_queue.sv -----
// Two-word queue between the front and back ends.
`default_nettype none
module chte_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              not_empty,
  output logic [W-1:0]      pop_data
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ----- design/chte_back.sv -----
// Back end: bin scan, slot update and compaction, result register.
`default_nettype none
module chte_back #(
  parameter int MAX_BINS    = chte_pkg::MAX_BINS_DEF,
  parameter int BIN_SLOTS   = chte_pkg::BIN_SLOTS_DEF,
  parameter int VALUE_WIDTH = chte_pkg::VALUE_WIDTH_DEF,
  localparam int BIN_DEPTH  = chte_pkg::bin_depth(MAX_BINS),
  localparam int BIN_W      = chte_pkg::idx_w(BIN_DEPTH)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_not_empty,
  output logic                                   q_pop,
  input  wire chte_pkg::action_t                 q_action,
  input  wire logic [chte_pkg::HASH_W-1:0]       q_hash,
  input  wire logic [VALUE_WIDTH-1:0]            q_value,
  input  wire logic [BIN_W-1:0]                  q_bin,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [chte_pkg::STATUS_W-1:0]          out_status,
  output logic [chte_pkg::IOVAL_W-1:0]           out_value_out,
  output logic [chte_pkg::COUNT_W-1:0]           out_entry_count
);

  localparam int SLOT_W     = chte_pkg::idx_w(BIN_SLOTS);
  localparam int FILL_W     = $clog2(BIN_SLOTS + 1);
  localparam int SLOT_DEPTH = BIN_DEPTH * (2 ** SLOT_W);
  localparam int CW         = chte_pkg::COUNT_W;

  typedef enum logic [6:0] {
    B_CLR   = 7'b0000001,
    B_IDLE  = 7'b0000010,
    B_FILL  = 7'b0000100,
    B_SCAN  = 7'b0001000,
    B_RES   = 7'b0010000,
    B_SHIFT = 7'b0100000,
    B_DONE  = 7'b1000000
  } bstate_t;

  bstate_t                      st_r, st_nxt;
  logic [BIN_W-1:0]             clr_r;
  chte_pkg::action_t            act_r;
  logic [chte_pkg::HASH_W-1:0]  hash_r;
  logic [VALUE_WIDTH-1:0]       val_r, vout_r;
  logic [BIN_W-1:0]             bin_r;
  logic [FILL_W-1:0]            fill_r, sl_r;
  logic                         hit_r;
  chte_pkg::status_t            status_r;
  logic [CW-1:0]                total_r;
  logic                         ovalid_r;
  logic [chte_pkg::STATUS_W-1:0] ostatus_r;
  logic [chte_pkg::IOVAL_W-1:0] ovalue_r;
  logic [CW-1:0]                ocount_r;

  logic [FILL_W-1:0]            fill_mem [BIN_DEPTH];
  logic [FILL_W-1:0]            fill_rd;
  logic [chte_pkg::HASH_W-1:0]  hash_mem [SLOT_DEPTH];
  logic [VALUE_WIDTH-1:0]       val_mem  [SLOT_DEPTH];
  logic [chte_pkg::HASH_W-1:0]  hash_rd;
  logic [VALUE_WIDTH-1:0]       val_rd;

  logic                         fill_we;
  logic [BIN_W-1:0]             fill_wa;
  logic [FILL_W-1:0]            fill_wd;
  logic                         hash_we, val_we;
  logic [FILL_W-1:0]            wr_sl;
  logic [chte_pkg::HASH_W-1:0]  hash_wd;
  logic [VALUE_WIDTH-1:0]       val_wd;
  logic [FILL_W:0]              rd_sl;
  logic [BIN_W+SLOT_W-1:0]      rd_addr, wr_addr;
  logic [FILL_W:0]              sl_p1, sl_p2, fill_x;
  logic                         more1, more2, full_bin, out_free;
  logic [63:0]                  vo64;

  assign sl_p1    = {1'b0, sl_r} + (FILL_W+1)'(1);
  assign sl_p2    = {1'b0, sl_r} + (FILL_W+1)'(2);
  assign fill_x   = {1'b0, fill_r};
  assign more1    = sl_p1 < fill_x;
  assign more2    = sl_p2 < fill_x;
  assign full_bin = (fill_x >= (FILL_W+1)'(BIN_SLOTS));
  assign out_free = !ovalid_r || !out_stall;
  assign q_pop    = (st_r == B_IDLE) && q_not_empty;

  always_comb begin
    case (st_r)
      B_SCAN, B_RES: rd_sl = sl_p1;
      B_SHIFT:       rd_sl = sl_p2;
      default:       rd_sl = '0;
    endcase
  end
  assign rd_addr = {bin_r, rd_sl[SLOT_W-1:0]};
  assign wr_addr = {bin_r, wr_sl[SLOT_W-1:0]};

  // write side of the stores
  always_comb begin
    fill_we = 1'b0;
    fill_wa = bin_r;
    fill_wd = fill_r;
    hash_we = 1'b0;
    val_we  = 1'b0;
    wr_sl   = sl_r;
    hash_wd = hash_r;
    val_wd  = val_r;
    case (st_r)
      B_CLR: begin
        fill_we = 1'b1;
        fill_wa = clr_r;
        fill_wd = '0;
      end
      B_RES: begin
        if (act_r == chte_pkg::ACT_PUT) begin
          if (hit_r) begin
            val_we = 1'b1;
          end else if (!full_bin) begin
            hash_we = 1'b1;
            val_we  = 1'b1;
            wr_sl   = fill_r;
            fill_we = 1'b1;
            fill_wd = fill_r + FILL_W'(1);
          end
        end else if (act_r == chte_pkg::ACT_REMOVE && hit_r) begin
          fill_we = 1'b1;
          fill_wd = fill_r - FILL_W'(1);
        end
      end
      B_SHIFT: begin
        hash_we = 1'b1;
        val_we  = 1'b1;
        hash_wd = hash_rd;
        val_wd  = val_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    fill_rd <= fill_mem[q_bin];
  end

  always_ff @(posedge clk) begin
    if (hash_we) begin
      hash_mem[wr_addr] <= hash_wd;
    end
    hash_rd <= hash_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= val_wd;
    end
    val_rd <= val_mem[rd_addr];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_CLR:   if (clr_r == BIN_W'(BIN_DEPTH - 1)) st_nxt = B_IDLE;
      B_IDLE:  if (q_not_empty) st_nxt = B_FILL;
      B_FILL:  st_nxt = (fill_rd == '0) ? B_RES : B_SCAN;
      B_SCAN: begin
        if (hash_rd == hash_r || !more1) begin
          st_nxt = B_RES;
        end
      end
      B_RES: begin
        st_nxt = (act_r == chte_pkg::ACT_REMOVE && hit_r && more1) ? B_SHIFT : B_DONE;
      end
      B_SHIFT: if (!more2) st_nxt = B_DONE;
      B_DONE:  if (out_free) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_CLR;
      clr_r    <= '0;
      total_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == B_CLR) begin
        clr_r <= clr_r + BIN_W'(1);
      end
      if (st_r == B_RES) begin
        if (act_r == chte_pkg::ACT_PUT && !hit_r && !full_bin) begin
          total_r <= total_r + CW'(1);
        end else if (act_r == chte_pkg::ACT_REMOVE && hit_r) begin
          total_r <= total_r - CW'(1);
        end
      end
      if (st_r == B_DONE && out_free) begin
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign vo64 = 64'(vout_r);

  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: begin
        act_r  <= q_action;
        hash_r <= q_hash;
        val_r  <= q_value;
        bin_r  <= q_bin;
      end
      B_FILL: begin
        fill_r <= fill_rd;
        sl_r   <= '0;
        hit_r  <= 1'b0;
      end
      B_SCAN: begin
        if (hash_rd == hash_r) begin
          hit_r  <= 1'b1;
          vout_r <= val_rd;
        end else if (more1) begin
          sl_r <= sl_p1[FILL_W-1:0];
        end
      end
      B_RES: begin
        case (act_r)
          chte_pkg::ACT_PUT: begin
            if (hit_r) begin
              status_r <= chte_pkg::ST_REPLACED;
            end else if (full_bin) begin
              status_r <= chte_pkg::ST_FULL;
              vout_r   <= '0;
            end else begin
              status_r <= chte_pkg::ST_INSERTED;
              vout_r   <= val_r;
            end
          end
          chte_pkg::ACT_GET: begin
            status_r <= hit_r ? chte_pkg::ST_FOUND : chte_pkg::ST_NOT_FOUND;
            if (!hit_r) vout_r <= '0;
          end
          chte_pkg::ACT_REMOVE: begin
            status_r <= hit_r ? chte_pkg::ST_REMOVED : chte_pkg::ST_NOT_FOUND;
            if (!hit_r) vout_r <= '0;
          end
          default: begin
            status_r <= hit_r ? chte_pkg::ST_FOUND : chte_pkg::ST_NOT_FOUND;
            vout_r   <= '0;
          end
        endcase
      end
      B_SHIFT: begin
        sl_r <= sl_p1[FILL_W-1:0];
      end
      B_DONE: begin
        if (out_free) begin
          ostatus_r <= status_r;
          ovalue_r  <= vo64[chte_pkg::IOVAL_W-1:0];
          ocount_r  <= total_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = ovalid_r;
  assign out_status      = ostatus_r;
  assign out_value_out   = ovalue_r;
  assign out_entry_count = ocount_r;

endmodule
`default_nettype wire

// ----- design/chained_hash_table_engine_top.sv -----
// Chained hash table engine: bin count register, front end, queue and back end.
// Usage:
//  - Requests enter on in_valid/in_stall with in_action, in_key_hash and in_value_in;
//    a word is taken at an edge with in_valid high and in_stall low.
//  - Each request gives one result word on out_valid/out_stall: out_status,
//    out_value_out and out_entry_count.
//  - cfg_we/cfg_wdata set the bin count; write it only while the engine is idle.
//  - The front end forms hash mod bin count (clamped to 1..MAX_BINS), four bits
//    per cycle, then hands the word to a two-word queue; in_stall stays high from
//    the take until the queue accepts, so no new word is taken before that.
//  - The back end pops a word, reads the bin fill, scans the bin slot by slot,
//    sets the result and, when a remove compacts the bin, moves each later slot down.
//    Front and back overlap, so throughput is set by the slower of the two.
//  - After reset the back end sweeps the bin fill store, one bin per cycle;
//    requests queue up but are not served
//    until the sweep ends. The bin count resets to 20 and the entry count to 0.
//  - A stalled result stays in the output register; the back end finishes the
//    next request and waits, while the front end keeps filling the queue.
`default_nettype none
module chained_hash_table_engine_top #(
  parameter int MAX_BINS    = chte_pkg::MAX_BINS_DEF,
  parameter int BIN_SLOTS   = chte_pkg::BIN_SLOTS_DEF,
  parameter int VALUE_WIDTH = chte_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [chte_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [chte_pkg::ACTION_W-1:0]     in_action,
  input  wire logic [chte_pkg::HASH_W-1:0]       in_key_hash,
  input  wire logic [chte_pkg::IOVAL_W-1:0]      in_value_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [chte_pkg::STATUS_W-1:0]          out_status,
  output logic [chte_pkg::IOVAL_W-1:0]           out_value_out,
  output logic [chte_pkg::COUNT_W-1:0]           out_entry_count
);

  localparam int BIN_W = chte_pkg::idx_w(chte_pkg::bin_depth(MAX_BINS));
  localparam int QW    = chte_pkg::ACTION_W + chte_pkg::HASH_W + VALUE_WIDTH + BIN_W;

  logic [chte_pkg::CFG_W-1:0]   bin_count_r;
  logic                         q_push, q_full, q_pop, q_not_empty;
  chte_pkg::action_t            f_action, b_action;
  logic [chte_pkg::HASH_W-1:0]  f_hash, b_hash;
  logic [VALUE_WIDTH-1:0]       f_value, b_value;
  logic [BIN_W-1:0]             f_bin, b_bin;
  logic [QW-1:0]                q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= chte_pkg::BIN_COUNT_RST;
    end else if (cfg_we) begin
      bin_count_r <= cfg_wdata;
    end
  end

  chte_front #(
    .MAX_BINS    (MAX_BINS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .bin_count   (bin_count_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_key_hash (in_key_hash),
    .in_value_in (in_value_in),
    .q_push      (q_push),
    .q_full      (q_full),
    .q_action    (f_action),
    .q_hash      (f_hash),
    .q_value     (f_value),
    .q_bin       (f_bin)
  );

  assign q_in = {f_action, f_hash, f_value, f_bin};

  chte_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  assign b_action = chte_pkg::action_t'(q_out[QW-1 -: chte_pkg::ACTION_W]);
  assign b_hash   = q_out[QW-chte_pkg::ACTION_W-1 -: chte_pkg::HASH_W];
  assign b_value  = q_out[BIN_W+VALUE_WIDTH-1 -: VALUE_WIDTH];
  assign b_bin    = q_out[BIN_W-1:0];

  chte_back #(
    .MAX_BINS    (MAX_BINS),
    .BIN_SLOTS   (BIN_SLOTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_pop           (q_pop),
    .q_action        (b_action),
    .q_hash          (b_hash),
    .q_value         (b_value),
    .q_bin           (b_bin),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_value_out   (out_value_out),
    .out_entry_count (out_entry_count)
  );

endmodule
`default_nettype wire

// ----- bench/chained_hash_table_engine_top_tb.sv -----
// Testbench for the chained hash table engine: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps
module chained_hash_table_engine_top_tb;

  localparam int NBINS      = 256;
  localparam int NSLOTS     = 8;
  localparam int IDLE_LIMIT = 5000;
  localparam int RAND_ITEMS = 1200;

  typedef struct packed {
    chte_pkg::status_t                st;
    logic [chte_pkg::IOVAL_W-1:0]     val;
    logic [chte_pkg::COUNT_W-1:0]     cnt;
  } answer_t;

  typedef struct {
    chte_pkg::action_t              act;
    logic [chte_pkg::HASH_W-1:0]    hash;
    logic [chte_pkg::IOVAL_W-1:0]   val;
    bit                             typed;
    answer_t                        ans;
  } req_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [chte_pkg::CFG_W-1:0]        cfg_wdata = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [chte_pkg::ACTION_W-1:0]     in_action = '0;
  logic [chte_pkg::HASH_W-1:0]       in_key_hash = '0;
  logic [chte_pkg::IOVAL_W-1:0]      in_value_in = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [chte_pkg::STATUS_W-1:0]     out_status;
  logic [chte_pkg::IOVAL_W-1:0]      out_value_out;
  logic [chte_pkg::COUNT_W-1:0]      out_entry_count;

  chained_hash_table_engine_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_key_hash(in_key_hash), .in_value_in(in_value_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_value_out(out_value_out), .out_entry_count(out_entry_count)
  );

  always #1 clk = ~clk;

  // shadow copy of the table
  logic [chte_pkg::CFG_W-1:0]     bin_count_sh;
  int unsigned                    fill_sh [NBINS];
  logic [chte_pkg::HASH_W-1:0]    hash_sh [NBINS*NSLOTS];
  logic [chte_pkg::IOVAL_W-1:0]   val_sh [NBINS*NSLOTS];
  logic [chte_pkg::COUNT_W-1:0]   total_sh;

  answer_t                        pending_answers[$];
  req_row_t                       directed_rows[$];
  logic [chte_pkg::HASH_W-1:0]    key_pool[16];
  int                             fails = 0;
  int                             idle_cycles = 0;
  bit                             calm = 1'b0;
  int                             stall_left = 0;

  function automatic answer_t table_lookup(chte_pkg::action_t act,
                                           logic [chte_pkg::HASH_W-1:0] h,
                                           logic [chte_pkg::IOVAL_W-1:0] v);
    int unsigned nb;
    int unsigned bin;
    int unsigned base;
    int          hit;
    answer_t     a;
    nb = (bin_count_sh == 0) ? 1 : (bin_count_sh > NBINS ? NBINS : bin_count_sh);
    bin = h % nb;
    base = bin * NSLOTS;
    hit = -1;
    a.val = '0;
    for (int s = 0; s < fill_sh[bin]; s++)
      if (hit < 0 && hash_sh[base+s] == h) hit = s;
    if (act == chte_pkg::ACT_PUT) begin
      if (hit >= 0) begin
        a.val = val_sh[base+hit];
        val_sh[base+hit] = v;
        a.st = chte_pkg::ST_REPLACED;
      end else if (fill_sh[bin] >= NSLOTS) begin
        a.st = chte_pkg::ST_FULL;
      end else begin
        hash_sh[base+fill_sh[bin]] = h;
        val_sh[base+fill_sh[bin]] = v;
        fill_sh[bin]++;
        total_sh++;
        a.val = v;
        a.st = chte_pkg::ST_INSERTED;
      end
    end else if (hit < 0) begin
      a.st = chte_pkg::ST_NOT_FOUND;
    end else if (act == chte_pkg::ACT_GET) begin
      a.val = val_sh[base+hit];
      a.st = chte_pkg::ST_FOUND;
    end else if (act == chte_pkg::ACT_REMOVE) begin
      a.val = val_sh[base+hit];
      // close the gap left in the bin
      for (int s = hit; s + 1 < fill_sh[bin]; s++) begin
        hash_sh[base+s] = hash_sh[base+s+1];
        val_sh[base+s] = val_sh[base+s+1];
      end
      fill_sh[bin]--;
      total_sh--;
      a.st = chte_pkg::ST_REMOVED;
    end else begin
      a.st = chte_pkg::ST_FOUND;
    end
    a.cnt = total_sh;
    return a;
  endfunction

  function automatic void add_row(chte_pkg::action_t act, logic [chte_pkg::HASH_W-1:0] h,
                                  logic [chte_pkg::IOVAL_W-1:0] v, bit typed = 1'b0,
                                  chte_pkg::status_t st = chte_pkg::ST_INSERTED,
                                  logic [chte_pkg::IOVAL_W-1:0] vo = '0,
                                  logic [chte_pkg::COUNT_W-1:0] cnt = '0);
    req_row_t r;
    r.act = act; r.hash = h; r.val = v; r.typed = typed;
    r.ans.st = st; r.ans.val = vo; r.ans.cnt = cnt;
    directed_rows.push_back(r);
  endfunction

  task automatic send_word(chte_pkg::action_t act, logic [chte_pkg::HASH_W-1:0] h,
                           logic [chte_pkg::IOVAL_W-1:0] v,
                           bit typed, answer_t typed_ans);
    answer_t a;
    int      gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_action = act;
    in_key_hash = h;
    in_value_in = v;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    a = table_lookup(act, h, v);
    pending_answers.push_back(typed ? typed_ans : a);
    gap = calm ? 0 : ($urandom_range(0, 9) < 6 ? 0 :
                      ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3)
                                                : $urandom_range(10, 40)));
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_action = chte_pkg::ACTION_W'($urandom);
      in_key_hash = $urandom;
      in_value_in = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_bin_count(logic [chte_pkg::CFG_W-1:0] n);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_answers.size() == 0);
    // nothing left to report, but let the back end settle
    repeat (30) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = n;
    @(negedge clk);
    cfg_we = 1'b0;
    bin_count_sh = n;
  endtask

  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 9) < 3);
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    answer_t exp_a;
    if (out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result word status=%0d value=%h count=%0d",
                 $time, out_status, out_value_out, out_entry_count);
        fails++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (out_status !== exp_a.st) begin
          $display("%0t: status expected %0d got %0d", $time, exp_a.st, out_status);
          fails++;
        end
        if (out_value_out !== exp_a.val) begin
          $display("%0t: value_out expected %h got %h", $time, exp_a.val, out_value_out);
          fails++;
        end
        if (out_entry_count !== exp_a.cnt) begin
          $display("%0t: entry_count expected %0d got %0d",
                   $time, exp_a.cnt, out_entry_count);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [chte_pkg::CFG_W-1:0]  phase_bins[8];
    answer_t                     none;
    int unsigned                 nb;
    int unsigned                 pick;
    chte_pkg::action_t           act;
    logic [chte_pkg::HASH_W-1:0] h;
    phase_bins = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd3, 9'd100, 9'd20, 9'd7};
    none = '0;
    bin_count_sh = chte_pkg::BIN_COUNT_RST;
    total_sh = '0;
    foreach (fill_sh[i]) fill_sh[i] = 0;

    add_row(chte_pkg::ACT_GET, 32'd5, 32'hFFFFFFFF, 1, chte_pkg::ST_NOT_FOUND, 32'd0, 12'd0);
    add_row(chte_pkg::ACT_PUT, 32'd5, 32'hFFFFFFFF, 1, chte_pkg::ST_INSERTED,
            32'hFFFFFFFF, 12'd1);
    add_row(chte_pkg::ACT_PUT, 32'd5, 32'd0, 1, chte_pkg::ST_REPLACED, 32'hFFFFFFFF, 12'd1);
    add_row(chte_pkg::ACT_GET, 32'd5, 32'd0, 1, chte_pkg::ST_FOUND, 32'd0, 12'd1);
    add_row(chte_pkg::ACT_CONTAINS, 32'd5, 32'd0, 1, chte_pkg::ST_FOUND, 32'd0, 12'd1);
    add_row(chte_pkg::ACT_CONTAINS, 32'd25, 32'd0, 1, chte_pkg::ST_NOT_FOUND, 32'd0, 12'd1);
    add_row(chte_pkg::ACT_REMOVE, 32'd25, 32'd0, 1, chte_pkg::ST_NOT_FOUND, 32'd0, 12'd1);
    add_row(chte_pkg::ACT_REMOVE, 32'd5, 32'd0, 1, chte_pkg::ST_REMOVED, 32'd0, 12'd0);
    // fill bin 3 to the brim, then overflow it
    for (int k = 0; k < NSLOTS; k++) add_row(chte_pkg::ACT_PUT, 32'd3 + 20*k, 32'h100 + k);
    add_row(chte_pkg::ACT_PUT, 32'd183, 32'h1234, 1, chte_pkg::ST_FULL, 32'd0, 12'd8);
    add_row(chte_pkg::ACT_REMOVE, 32'd63, 32'd0);
    add_row(chte_pkg::ACT_GET, 32'd163, 32'd0);
    add_row(chte_pkg::ACT_PUT, 32'd183, 32'h5A5A5A5A);
    add_row(chte_pkg::ACT_PUT, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_row(chte_pkg::ACT_GET, 32'hFFFFFFFF, 32'd0);
    add_row(chte_pkg::ACT_REMOVE, 32'd3, 32'd0);
    add_row(chte_pkg::ACT_CONTAINS, 32'd143, 32'd0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].act, directed_rows[i].hash, directed_rows[i].val,
                directed_rows[i].typed, directed_rows[i].ans);

    foreach (phase_bins[p]) begin
      write_bin_count(phase_bins[p]);
      calm = (p == 2);
      nb = (phase_bins[p] == 0) ? 1 : (phase_bins[p] > NBINS ? NBINS : phase_bins[p]);
      // keys crowd into a few bins so that hits, full bins and compaction occur
      foreach (key_pool[k])
        key_pool[k] = $urandom_range(0, 3) + nb * ($urandom % (32'hFFFFFFFF / nb));
      for (int n = 0; n < RAND_ITEMS / 8; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) act = chte_pkg::ACT_PUT;
        else if (pick < 65) act = chte_pkg::ACT_GET;
        else if (pick < 85) act = chte_pkg::ACT_REMOVE;
        else act = chte_pkg::ACT_CONTAINS;
        h = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
        send_word(act, h, $urandom, 1'b0, none);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    calm = 1'b1;
    wait (pending_answers.size() == 0);
    repeat (40) @(posedge clk);
    if (fails == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
